### sv/bdar_pkg.sv
// Package for the button debounce / auto-repeat block.
// Register index codes, configuration and result word types, width constants.
// No dependencies.
package bdar_pkg;

  localparam int unsigned HELD_TIME_BITS_DEF = 32;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  localparam int unsigned CHECK_BITS  = 9;
  localparam int unsigned REPEAT_TICK_BITS = 17;
  localparam int unsigned REPEATS_BITS = 16;
  localparam int unsigned HELD_OUT_BITS = 32;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE       = 3'd0,
    REG_ACTIVE_LEVEL = 3'd1,
    REG_DEBOUNCE_MS  = 3'd2,
    REG_REPEAT_MS    = 3'd3,
    REG_CHECK_PERIOD = 3'd4
  } bdar_reg_e;

  typedef struct packed {
    logic        enable;
    logic        active_level;
    logic [15:0] debounce_ms;
    logic [15:0] repeat_ms;
    logic [7:0]  check_period_ms;
  } bdar_cfg_t;

  typedef struct packed {
    logic                     pressed;
    logic [HELD_OUT_BITS-1:0] held_ms;
    logic [REPEATS_BITS-1:0]  repeat_count;
  } bdar_res_t;

endpackage

### sv/bdar_core.sv
// Debounce / auto-repeat state and per-tick update logic.
// Takes one tick per step strobe and flags a result word when one is due.
// Depends on bdar_pkg.
module bdar_core
  import bdar_pkg::*;
#(
  parameter int unsigned HELD_TIME_BITS = HELD_TIME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      pin_level_i,
  input  bdar_cfg_t cfg_i,
  output logic      res_valid_o,
  output bdar_res_t res_o
);

  logic [CHECK_BITS-1:0]       tsc_q, tsc_d, tsc_inc;
  logic [REPEAT_TICK_BITS-1:0] tsr_q, tsr_d, tsr_inc;
  logic [HELD_TIME_BITS-1:0]   held_q, held_d, held_new;
  logic [HELD_TIME_BITS:0]     held_sum;
  logic [REPEATS_BITS-1:0]     reps_q, reps_d, reps_inc;
  logic                        stable_q, stable_d;
  logic                        first_q, first_d;
  logic                        cur;
  logic [HELD_OUT_BITS-1:0]    held_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsc_q    <= '0;
      tsr_q    <= '0;
      held_q   <= '0;
      reps_q   <= '0;
      stable_q <= 1'b0;
      first_q  <= 1'b1;
    end else begin
      tsc_q    <= tsc_d;
      tsr_q    <= tsr_d;
      held_q   <= held_d;
      reps_q   <= reps_d;
      stable_q <= stable_d;
      first_q  <= first_d;
    end
  end

  // saturating counters
  assign tsc_inc  = (&tsc_q)  ? tsc_q  : tsc_q + 1'b1;
  assign tsr_inc  = (&tsr_q)  ? tsr_q  : tsr_q + 1'b1;
  assign reps_inc = (&reps_q) ? reps_q : reps_q + 1'b1;

  assign held_sum = {1'b0, held_q} + (HELD_TIME_BITS + 1)'(tsc_inc);
  assign held_new = held_sum[HELD_TIME_BITS] ? '1 : held_sum[HELD_TIME_BITS-1:0];

  assign cur = (pin_level_i == cfg_i.active_level);

  // reported held time clamps at 32 bits
  if (HELD_TIME_BITS > HELD_OUT_BITS) begin : g_held_clamp
    assign held_out = (|held_new[HELD_TIME_BITS-1:HELD_OUT_BITS]) ? '1
                    : held_new[HELD_OUT_BITS-1:0];
  end else begin : g_held_ext
    assign held_out = HELD_OUT_BITS'(held_new);
  end

  always_comb begin
    tsc_d       = tsc_q;
    tsr_d       = tsr_q;
    held_d      = held_q;
    reps_d      = reps_q;
    stable_d    = stable_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '{pressed: cur, held_ms: held_out, repeat_count: '0};

    if (step_i && cfg_i.enable) begin
      tsc_d = tsc_inc;
      tsr_d = tsr_inc;
      if (tsc_inc > {1'b0, cfg_i.check_period_ms}) begin
        // pin evaluation
        tsc_d  = '0;
        held_d = held_new;
        if (first_q) begin
          stable_d = cur;
          first_d  = 1'b0;
        end else if (cur != stable_q) begin
          if (held_new > HELD_TIME_BITS'(cfg_i.debounce_ms)) begin
            stable_d    = cur;
            held_d      = '0;
            tsr_d       = '0;
            reps_d      = '0;
            res_valid_o = 1'b1;
          end
        end else if (cur && (tsr_inc > {1'b0, cfg_i.repeat_ms})) begin
          tsr_d              = '0;
          reps_d             = reps_inc;
          res_valid_o        = 1'b1;
          res_o.pressed      = 1'b1;
          res_o.repeat_count = reps_inc;
        end
      end
    end
  end

endmodule

### sv/button_debounce_auto_repeat.sv
// Button debounce with auto-repeat: top level with ports, config registers,
// input and result registers. Depends on bdar_pkg and bdar_core.
//
// Each input word is one millisecond tick carrying the raw pin level. Once
// the ticks since the last evaluation exceed the check period, the pin is
// evaluated: the first evaluation only latches the stable level; later a
// change of level is reported (repeat_count 0) once the held time exceeds
// debounce_ms, and while the button stays pressed a repeat word (repeat_count
// 1, 2 and so on) follows each time repeat_ms is exceeded. held_ms carries the
// time in the current state, saturating. Throughput is one tick per clock
// while the output is not stalled; a tick passes the input register and
// bdar_core into the result register. Ticks that cause no result vanish. The
// result register holds a word under out_stall_i while the input register
// still takes the next tick. Registers (enable, active_level, debounce_ms,
// repeat_ms, check_period_ms at indexes 0..4) must be written with the block
// idle; the block does not enforce this. cfg_ready_o is always high and writes
// to other indexes are dropped. Writes do not disturb the counters.
module button_debounce_auto_repeat
  import bdar_pkg::*;
#(
  parameter int unsigned HELD_TIME_BITS = HELD_TIME_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // tick input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      pin_level_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      pressed_o,
  output logic [HELD_OUT_BITS-1:0]  held_ms_o,
  output logic [REPEATS_BITS-1:0]   repeat_count_o,
  // configuration write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  bdar_cfg_t cfg_q, cfg_d;

  logic      in_vld_q, in_vld_d;
  logic      pin_q;
  logic      out_vld_q, out_vld_d;
  bdar_res_t out_q;

  logic      advance;
  logic      step;
  logic      in_take;
  logic      res_valid;
  bdar_res_t res;

  // ---------------- configuration registers ----------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (bdar_reg_e'(cfg_index_i))
        REG_ENABLE:       cfg_d.enable          = cfg_data_i[0];
        REG_ACTIVE_LEVEL: cfg_d.active_level    = cfg_data_i[0];
        REG_DEBOUNCE_MS:  cfg_d.debounce_ms     = cfg_data_i;
        REG_REPEAT_MS:    cfg_d.repeat_ms       = cfg_data_i;
        REG_CHECK_PERIOD: cfg_d.check_period_ms = cfg_data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: 1'b0, active_level: 1'b0, debounce_ms: 16'd50,
                 repeat_ms: 16'd500, check_period_ms: 8'd10};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- flow control ----------------
  // update stage moves when the result register is free or being emptied
  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q <= pin_level_i;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  // ---------------- tick update ----------------
  bdar_core #(
    .HELD_TIME_BITS(HELD_TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_level_i (pin_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o    = out_vld_q;
  assign pressed_o      = out_q.pressed;
  assign held_ms_o      = out_q.held_ms;
  assign repeat_count_o = out_q.repeat_count;

endmodule
